// ----- hw/rtl/rbpd_pkg.sv -----
`timescale 1ns / 1ps

package rbpd_pkg;

  // Frame geometry defaults
  localparam int FRAME_WIDTH_DEF  = 640;
  localparam int FRAME_HEIGHT_DEF = 480;

  // Wide enough for any clamp bound up to 4096
  localparam int COORD_W = 13;

  // Queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROI_X_LOW      = 3'd0,
    REG_ROI_X_HIGH     = 3'd1,
    REG_ROI_Y_LOW      = 3'd2,
    REG_ROI_Y_HIGH     = 3'd3,
    REG_BIN_THRESHOLD  = 3'd4,
    REG_PIX_THRESHOLD  = 3'd5,
    REG_FRAME_TRIGGER  = 3'd6
  } cfg_reg_e;

  // Saturation limits
  localparam logic [18:0] TALLY_MAX  = 19'h7FFFF;
  localparam logic [9:0]  STREAK_MAX = 10'h3FF;

  // Luma weights and rounding
  localparam logic [10:0] W_BLUE  = 11'd1868;
  localparam logic [13:0] W_GREEN = 14'd9617;
  localparam logic [12:0] W_RED   = 13'd4899;
  localparam logic [21:0] LUMA_RND = 22'd8192;
  localparam logic [COORD_W-1:0] GRAY_LIMIT = COORD_W'(255);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [9:0] column;
    logic [8:0] row_index;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    logic [18:0] bright_count;
    logic        region_found;
    logic [9:0]  frames_in_row;
    logic        detected;
  } result_t;

  typedef struct packed {
    logic [9:0]  roi_x_low;
    logic [9:0]  roi_x_high;
    logic [8:0]  roi_y_low;
    logic [8:0]  roi_y_high;
    logic [7:0]  binary_threshold;
    logic [18:0] pixel_count_threshold;
    logic [9:0]  frame_trigger;
  } cfg_t;

  // One classified pixel in the queue
  typedef struct packed {
    logic bright;
    logic last;
  } token_t;

  // Limit v to 1 .. hi-1, lower bound wins
  function automatic logic [COORD_W-1:0] clamp_edge(
    input logic [COORD_W-1:0] v,
    input logic [COORD_W-1:0] hi
  );
    logic [COORD_W-1:0] r;
    r = (v < hi - COORD_W'(1)) ? v : hi - COORD_W'(1);
    return (r > COORD_W'(1)) ? r : COORD_W'(1);
  endfunction

endpackage

// ----- hw/rtl/rbpd_front.sv -----
`timescale 1ns / 1ps

module rbpd_front import rbpd_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   pix_valid_i,
  input  pixel_t pix_i,
  output logic   pix_stall_o,
  output logic   push_o,
  output token_t push_data_o,
  input  logic   q_full_i
);

  localparam logic [COORD_W-1:0] X_LOW_HI  = COORD_W'(FRAME_WIDTH / 2);
  localparam logic [COORD_W-1:0] X_HIGH_HI = COORD_W'(FRAME_WIDTH);
  localparam logic [COORD_W-1:0] Y_LOW_HI  = COORD_W'(FRAME_HEIGHT / 2);
  localparam logic [COORD_W-1:0] Y_HIGH_HI = COORD_W'(FRAME_HEIGHT);

  logic [COORD_W-1:0] xl, xh, yl, yh, col, row;
  logic [COORD_W-1:0] thr_wide;
  logic [7:0]  thr;
  logic        in_roi;
  logic        accept, advance;

  logic        vld_q, vld_d;
  logic [18:0] pb_q;
  logic [21:0] pg_q;
  logic [20:0] pr_q;
  logic        in_roi_q, last_q;

  logic [21:0] luma_sum;
  logic [7:0]  gray;

  // Clamped region and threshold
  assign xl  = clamp_edge(COORD_W'(cfg_i.roi_x_low),  X_LOW_HI);
  assign xh  = clamp_edge(COORD_W'(cfg_i.roi_x_high), X_HIGH_HI);
  assign yl  = clamp_edge(COORD_W'(cfg_i.roi_y_low),  Y_LOW_HI);
  assign yh  = clamp_edge(COORD_W'(cfg_i.roi_y_high), Y_HIGH_HI);
  assign thr_wide = clamp_edge(COORD_W'(cfg_i.binary_threshold), GRAY_LIMIT);
  assign thr = thr_wide[7:0];

  assign col = COORD_W'(pix_i.column);
  assign row = COORD_W'(pix_i.row_index);
  assign in_roi = (col >= xl) && (col < xh) && (row >= yl) && (row < yh);

  // Stage moves when empty or the queue takes its token
  assign advance     = !vld_q || !q_full_i;
  assign pix_stall_o = vld_q && q_full_i;
  assign accept      = pix_valid_i && !pix_stall_o;
  assign vld_d       = accept ? 1'b1 : (advance ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Products and region flag, registered
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pb_q     <= 19'(W_BLUE) * 19'(pix_i.blue);
      pg_q     <= 22'(W_GREEN) * 22'(pix_i.green);
      pr_q     <= 21'(W_RED) * 21'(pix_i.red);
      in_roi_q <= in_roi;
      last_q   <= pix_i.frame_end;
    end
  end

  // Sum, round, compare
  assign luma_sum = 22'(pb_q) + pg_q + 22'(pr_q) + LUMA_RND;
  assign gray     = luma_sum[21:14];

  assign push_o             = vld_q && !q_full_i;
  assign push_data_o.bright = in_roi_q && (gray > thr);
  assign push_data_o.last   = last_q;

endmodule

// ----- hw/rtl/rbpd_queue.sv -----
`timescale 1ns / 1ps

module rbpd_queue import rbpd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  token_t                   push_data_i,
  input  logic                     pop_i,
  output token_t                   pop_data_o,
  output logic                     full_o,
  output logic                     empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  token_t        mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  assign pop_data_o = mem_q[rd_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/rbpd_back.sv -----
`timescale 1ns / 1ps

module rbpd_back import rbpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    q_empty_i,
  input  token_t  q_data_i,
  output logic    pop_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_stall_i
);

  logic [18:0] tally_q, tally_d, count;
  logic [9:0]  streak_q, streak_d;
  logic        det_q, det_d;
  logic        out_vld_q, out_vld_d;
  result_t     out_q;
  logic        inc, found, emit;

  // Pop whenever the output slot is free or being drained
  assign pop_o = !q_empty_i && (!out_vld_q || !res_stall_i);
  assign emit  = pop_o && q_data_i.last;

  assign inc   = q_data_i.bright && (tally_q != TALLY_MAX);
  assign count = tally_q + 19'(inc);
  assign found = count > cfg_i.pixel_count_threshold;

  // Tally and streak updates
  always_comb begin
    tally_d  = tally_q;
    streak_d = streak_q;
    det_d    = det_q;
    if (pop_o) begin
      tally_d = q_data_i.last ? '0 : count;
    end
    if (emit) begin
      if (found) begin
        streak_d = (streak_q == STREAK_MAX) ? streak_q : streak_q + 10'd1;
        det_d    = det_q || (streak_d > cfg_i.frame_trigger);
      end else begin
        streak_d = '0;
        det_d    = 1'b0;
      end
    end
  end

  assign out_vld_d = emit ? 1'b1 : ((out_vld_q && res_stall_i) ? 1'b1 : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q   <= '0;
      streak_q  <= '0;
      det_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      tally_q   <= tally_d;
      streak_q  <= streak_d;
      det_q     <= det_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.bright_count  <= count;
      out_q.region_found  <= found;
      out_q.frames_in_row <= streak_d;
      out_q.detected      <= det_d;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

// ----- hw/rtl/roi_bright_pixel_frame_detector_core.sv -----
`timescale 1ns / 1ps

// Bright pixel detector for a region of interest. Takes one BGR pixel per
// cycle with its column, row and an end-of-frame mark; converts it to 8-bit
// luma, counts pixels above the clamped binary threshold inside the clamped
// region, and on the last pixel of each frame emits one result: the count,
// whether it beats the pixel count threshold, the run of consecutive found
// frames and the detected flag. Throughput is one pixel per clock unless the
// input is stalled; a pixel passes the product register, a queue entry and
// the result register. The front stage stalls only when the queue (default
// four entries) is full, which only follows a stalled result output; the
// input stall ends in the cycle after the result stall does. The user must
// write configuration through the register port only while no frame is in
// flight; the block does not enforce this. The port is always ready.

module roi_bright_pixel_frame_detector_core import rbpd_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pix_valid_i,
  input  pixel_t                pix_i,
  output logic                  pix_stall_o,
  output logic                  res_valid_o,
  output result_t               res_o,
  input  logic                  res_stall_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o
);

  cfg_t   cfg_q, cfg_d;
  logic   push, pop, q_full, q_empty;
  token_t push_data, pop_data;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  // Register file
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_ROI_X_LOW:     cfg_d.roi_x_low             = cfg_data_i[9:0];
        REG_ROI_X_HIGH:    cfg_d.roi_x_high            = cfg_data_i[9:0];
        REG_ROI_Y_LOW:     cfg_d.roi_y_low             = cfg_data_i[8:0];
        REG_ROI_Y_HIGH:    cfg_d.roi_y_high            = cfg_data_i[8:0];
        REG_BIN_THRESHOLD: cfg_d.binary_threshold      = cfg_data_i[7:0];
        REG_PIX_THRESHOLD: cfg_d.pixel_count_threshold = cfg_data_i[18:0];
        REG_FRAME_TRIGGER: cfg_d.frame_trigger         = cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roi_x_low             <= 10'd0;
      cfg_q.roi_x_high            <= 10'd639;
      cfg_q.roi_y_low             <= 9'd0;
      cfg_q.roi_y_high            <= 9'd479;
      cfg_q.binary_threshold      <= 8'd128;
      cfg_q.pixel_count_threshold <= 19'd1000;
      cfg_q.frame_trigger         <= 10'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rbpd_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_valid_i (pix_valid_i),
    .pix_i       (pix_i),
    .pix_stall_o (pix_stall_o),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  rbpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  rbpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .res_stall_i (res_stall_i)
  );

  // Checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_stall_o |-> q_full)
    else $error("front stalled with room in queue");

  a_full_needs_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_full && !pop) |-> (res_valid_o && res_stall_i))
    else $error("queue full but back not blocked");

  a_miss_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.region_found) |->
      (res_o.frames_in_row == '0 && !res_o.detected))
    else $error("missed frame left streak or detected set");

endmodule
